// File: rtl/core/route_builder_bfs_path_unit_assert.svh
// assertion macros for the route builder core
// used by route_builder_bfs_path_unit, needs clk and rst_n in scope
`ifndef ROUTE_BUILDER_BFS_PATH_UNIT_ASSERT_SVH
`define ROUTE_BUILDER_BFS_PATH_UNIT_ASSERT_SVH

// same-cycle implication
`define RBP_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("route builder assertion failed");

// next-cycle implication
`define RBP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("route builder assertion failed");

`endif

// File: rtl/core/rbp_pkg.sv
// types and constants of the route builder core
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package rbp_pkg;
  localparam int NODES       = 64;
  localparam int ROUTE_SLOTS = 64;
  localparam int MAX_DEGREE  = 8;
  localparam int NODE_W      = 6;
  localparam int SLOT_W      = 3;
  localparam int DEG_W       = 4;
  localparam int CAP_W       = 7;
  localparam int LEN_W       = 7;

  localparam logic [7:0]       END_MARK     = 8'hFF;
  localparam logic [CAP_W-1:0] MIN_CAPACITY = 7'd2;
  localparam logic [CAP_W-1:0] CAP_RESET    = 7'd64;
  localparam logic             REG_CAP_LIMIT = 1'b0;

  localparam logic [2:0] K_CLEAR  = 3'd0;
  localparam logic [2:0] K_NODE   = 3'd1;
  localparam logic [2:0] K_PATH   = 3'd2;
  localparam logic [2:0] K_CHECK  = 3'd3;
  localparam logic [2:0] K_COMMIT = 3'd4;
  localparam logic [2:0] K_WNB    = 3'd5;
  localparam logic [2:0] K_WDEG   = 3'd6;
  localparam logic [2:0] K_READ   = 3'd7;

  localparam logic [2:0] ST_OK   = 3'd0;
  localparam logic [2:0] ST_ARG  = 3'd1;
  localparam logic [2:0] ST_NODE = 3'd2;
  localparam logic [2:0] ST_FULL = 3'd3;
  localparam logic [2:0] ST_DISC = 3'd4;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] node;
    logic [7:0] target;
    logic [2:0] slot;
    logic [5:0] neighbor;
    logic [3:0] degree;
    logic [5:0] index;
  } in_t;

  typedef struct packed {
    logic [2:0] status;
    logic [5:0] route_length;
    logic       force_stop;
    logic [7:0] entry;
  } out_t;
endpackage
`default_nettype wire

// File: rtl/core/route_builder_bfs_path_unit.sv
// route builder core: adjacency table, bfs path append, validate and commit
// depends on rbp_pkg and route_builder_bfs_path_unit_assert.svh
//
// channel   direction  handshake          payload
// in        input      in_valid/in_stall  rbp_pkg::in_t
// out       output     out_valid/out_stall rbp_pkg::out_t
// cfg       input      apb write/read     capacity limit at address 0
//
// clear, append node, table writes: accept, then S_OUT; read route: S_RD, then S_OUT
// validate: S_V_RD, S_V_CHK, S_V_SCAN per route node; commit: S_C_RD, S_C_WR per node
// path: bfs search (S_B_POP to S_B_NEXT), predecessor walk (S_T_CHK, S_T_WAIT) per
// path node and append (S_A_RD, S_A_WR) per appended node, on registered table reads
// in_stall stays high from acceptance until the result is loaded into the
// output register; a stalled output only delays that load
// synchronous active-low reset, no clearing pass: valid bits cover the tables
`timescale 1ns / 1ps
`default_nettype none
module route_builder_bfs_path_unit (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire rbp_pkg::in_t  in_data,
  output logic               out_valid,
  input  wire logic          out_stall,
  output rbp_pkg::out_t      out_data,
  input  wire logic          psel,
  input  wire logic          penable,
  input  wire logic          pwrite,
  input  wire logic [2:0]    paddr,
  input  wire logic [31:0]   pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import rbp_pkg::*;

  typedef enum logic [16:0] {
    S_IDLE   = 17'h00001,
    S_OUT    = 17'h00002,
    S_RD     = 17'h00004,
    S_V_RD   = 17'h00008,
    S_V_CHK  = 17'h00010,
    S_V_SCAN = 17'h00020,
    S_C_RD   = 17'h00040,
    S_C_WR   = 17'h00080,
    S_B_POP  = 17'h00100,
    S_B_POPW = 17'h00200,
    S_B_DEG  = 17'h00400,
    S_B_SCAN = 17'h00800,
    S_B_NEXT = 17'h01000,
    S_T_CHK  = 17'h02000,
    S_T_WAIT = 17'h04000,
    S_A_RD   = 17'h08000,
    S_A_WR   = 17'h10000
  } state_t;

  state_t state_r;
  logic             out_valid_r;
  out_t             out_data_r;
  logic [CAP_W-1:0] cap_r;
  logic [5:0]       fill_r;
  logic [2:0]       pend_status_r;
  logic             pend_stop_r;
  logic [7:0]       pend_entry_r;
  logic             commit_r;
  logic [NODE_W-1:0] n_r, s_r, t_r;
  logic [7:0]       nx_r;
  logic [5:0]       i_r;
  logic [SLOT_W-1:0] slot_r;
  logic [DEG_W-1:0] d_r;
  logic [LEN_W-1:0] head_r, tail_r, len_r;
  logic [NODES-1:0] seen_r;
  logic [NODES-1:0] deg_valid_r;
  logic [ROUTE_SLOTS-1:0] act_valid_r;

  logic [7:0]        bs_mem  [ROUTE_SLOTS];
  logic [7:0]        act_mem [ROUTE_SLOTS];
  logic [DEG_W-1:0]  deg_mem [NODES];
  logic [NODE_W-1:0] nt_mem  [NODES*MAX_DEGREE];
  logic [NODE_W-1:0] pred_mem[NODES];
  logic [NODE_W-1:0] q_mem   [NODES];
  logic [NODE_W-1:0] rev_mem [NODES];

  logic [7:0]        bs_rd_r, act_rd_r;
  logic              act_v_q, deg_v_q;
  logic [DEG_W-1:0]  deg_rd_r;
  logic [NODE_W-1:0] nt_rd_r, pred_rd_r, q_rd_r, rev_rd_r;

  logic accept, cfg_wr, cap_ok, full, node_ok, tgt_ok, aw_ok, nt_ok, pre_bad;
  logic bs_we, deg_we, nt_we, act_we, q_we, pred_we, rev_we, trace_end;
  logic [CAP_W-1:0] cap;
  logic [7:0] bs_wd;
  logic [NODE_W-1:0] deg_ra, q_wd, pred_wa, pred_wd, q_wa;
  logic [SLOT_W-1:0] slot_sel;
  logic [DEG_W-1:0] deg_eff;
  logic slot_last;

  assign in_stall  = (state_r != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign pready    = 1'b1;
  assign cfg_wr    = psel && penable && pwrite && (paddr[2] == REG_CAP_LIMIT);
  assign prdata    = (paddr[2] == REG_CAP_LIMIT) ? {25'd0, cap_r} : 32'd0;

  assign cap     = (cap_r > CAP_W'(ROUTE_SLOTS)) ? CAP_W'(ROUTE_SLOTS) : cap_r;
  assign cap_ok  = (cap >= MIN_CAPACITY);
  assign full    = ({1'b0, fill_r} >= cap - 7'd1);
  assign node_ok = (in_data.node < 8'(NODES));
  assign tgt_ok  = (in_data.target < 8'(NODES));
  assign pre_bad = !cap_ok || (fill_r == 6'd0) || ({1'b0, fill_r} >= cap) || !node_ok;
  assign aw_ok   = cap_ok && ({1'b0, rev_rd_r} < 7'(NODES)) && !full;
  assign deg_eff = deg_v_q ? deg_rd_r : '0;
  assign nt_ok   = ({1'b0, nt_rd_r} < 7'(NODES)) && !seen_r[nt_rd_r]
                   && (tail_r < LEN_W'(NODES));
  assign slot_last = ({1'b0, slot_r} + 4'd1 == d_r);
  assign trace_end = (n_r == s_r) || (len_r == LEN_W'(NODES));

  always_comb begin
    bs_we  = (accept && in_data.kind == K_NODE && cap_ok && node_ok && !full)
             || (state_r == S_A_WR && aw_ok);
    bs_wd  = (state_r == S_IDLE) ? in_data.node : {2'b00, rev_rd_r};
    deg_we = accept && in_data.kind == K_WDEG && node_ok
             && (in_data.degree <= DEG_W'(MAX_DEGREE));
    nt_we  = accept && in_data.kind == K_WNB && node_ok
             && ({1'b0, in_data.neighbor} < 7'(NODES))
             && ({1'b0, in_data.slot} < 4'(MAX_DEGREE));
    act_we = (state_r == S_C_WR);
    q_we   = (accept && in_data.kind == K_PATH && node_ok && tgt_ok
              && in_data.node != in_data.target) || (state_r == S_B_SCAN && nt_ok);
    pred_we = q_we;
    q_wa    = (state_r == S_IDLE) ? '0 : tail_r[NODE_W-1:0];
    q_wd    = (state_r == S_IDLE) ? in_data.node[NODE_W-1:0] : nt_rd_r;
    pred_wa = q_wd;
    pred_wd = (state_r == S_IDLE) ? in_data.node[NODE_W-1:0] : n_r;
    rev_we  = (state_r == S_T_CHK) && !trace_end;
    deg_ra  = (state_r == S_B_POPW) ? q_rd_r : n_r;
    slot_sel = (state_r == S_V_CHK || state_r == S_B_DEG) ? '0 : slot_r + 3'd1;
  end

  // table and store memories
  always_ff @(posedge clk) begin
    if (bs_we) bs_mem[fill_r] <= bs_wd;
    bs_rd_r <= bs_mem[i_r];
    if (act_we) act_mem[i_r] <= bs_rd_r;
    act_rd_r <= act_mem[in_data.index];
    act_v_q  <= act_valid_r[in_data.index];
    if (deg_we) deg_mem[in_data.node[NODE_W-1:0]] <= in_data.degree;
    deg_rd_r <= deg_mem[deg_ra];
    deg_v_q  <= deg_valid_r[deg_ra];
    if (nt_we) nt_mem[{in_data.node[NODE_W-1:0], in_data.slot}] <= in_data.neighbor;
    nt_rd_r <= nt_mem[{n_r, slot_sel}];
    if (pred_we) pred_mem[pred_wa] <= pred_wd;
    pred_rd_r <= pred_mem[n_r];
    if (q_we) q_mem[q_wa] <= q_wd;
    q_rd_r <= q_mem[head_r[NODE_W-1:0]];
    if (rev_we) rev_mem[len_r[NODE_W-1:0]] <= n_r;
    rev_rd_r <= rev_mem[len_r[NODE_W-1:0] - 6'd1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      cap_r       <= CAP_RESET;
      fill_r      <= '0;
      seen_r      <= '0;
      deg_valid_r <= '0;
      act_valid_r <= '0;
    end else begin
      if (cfg_wr) cap_r <= pwdata[CAP_W-1:0];
      if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
      if (deg_we) deg_valid_r[in_data.node[NODE_W-1:0]] <= 1'b1;
      if (bs_we) fill_r <= fill_r + 6'd1;
      if (q_we) tail_r <= tail_r + 7'd1;
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            pend_status_r <= ST_OK;
            pend_stop_r   <= 1'b0;
            pend_entry_r  <= '0;
            state_r       <= S_OUT;
            unique case (in_data.kind)
              K_CLEAR: fill_r <= '0;
              K_NODE: begin
                if (!cap_ok) pend_status_r <= ST_ARG;
                else if (!node_ok) pend_status_r <= ST_NODE;
                else if (full) pend_status_r <= ST_FULL;
              end
              K_PATH: begin
                if (!node_ok || !tgt_ok) begin
                  pend_status_r <= ST_ARG;
                end else if (in_data.node != in_data.target) begin
                  seen_r <= '0;
                  seen_r[in_data.node[NODE_W-1:0]] <= 1'b1;
                  head_r  <= '0;
                  tail_r  <= 7'd1;
                  s_r     <= in_data.node[NODE_W-1:0];
                  t_r     <= in_data.target[NODE_W-1:0];
                  state_r <= S_B_POP;
                end
              end
              K_CHECK, K_COMMIT: begin
                commit_r <= (in_data.kind == K_COMMIT);
                if (pre_bad) begin
                  pend_status_r <= ST_ARG;
                  pend_stop_r   <= (in_data.kind == K_COMMIT);
                end else begin
                  n_r     <= in_data.node[NODE_W-1:0];
                  i_r     <= '0;
                  state_r <= S_V_RD;
                end
              end
              K_WNB: begin
                if (!node_ok || ({1'b0, in_data.neighbor} >= 7'(NODES)))
                  pend_status_r <= ST_NODE;
                else if ({1'b0, in_data.slot} >= 4'(MAX_DEGREE))
                  pend_status_r <= ST_ARG;
              end
              K_WDEG: begin
                if (!node_ok) pend_status_r <= ST_NODE;
                else if (in_data.degree > DEG_W'(MAX_DEGREE)) pend_status_r <= ST_ARG;
              end
              K_READ: state_r <= S_RD;
              default: state_r <= S_OUT;
            endcase
          end
        end
        S_RD: begin
          pend_entry_r <= ({1'b0, in_data.index} >= 7'(ROUTE_SLOTS)) || !act_v_q
                          ? END_MARK : act_rd_r;
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid_r || !out_stall) begin
            out_valid_r <= 1'b1;
            out_data_r  <= '{status: pend_status_r, route_length: fill_r,
                             force_stop: pend_stop_r, entry: pend_entry_r};
            state_r     <= S_IDLE;
          end
        end
        S_V_RD: state_r <= S_V_CHK;
        S_V_CHK: begin
          nx_r   <= bs_rd_r;
          slot_r <= '0;
          d_r    <= deg_eff;
          if (bs_rd_r >= 8'(NODES)) begin
            pend_status_r <= ST_NODE;
            pend_stop_r   <= commit_r;
            state_r       <= S_OUT;
          end else if (deg_eff == '0) begin
            pend_status_r <= ST_DISC;
            pend_stop_r   <= commit_r;
            state_r       <= S_OUT;
          end else begin
            state_r <= S_V_SCAN;
          end
        end
        S_V_SCAN: begin
          if ({2'b00, nt_rd_r} == nx_r) begin
            n_r <= nx_r[NODE_W-1:0];
            i_r <= i_r + 6'd1;
            if (i_r + 6'd1 == fill_r) begin
              if (commit_r) begin
                act_valid_r <= '0;
                i_r         <= '0;
                state_r     <= S_C_RD;
              end else begin
                state_r <= S_OUT;
              end
            end else begin
              state_r <= S_V_RD;
            end
          end else if (slot_last) begin
            pend_status_r <= ST_DISC;
            pend_stop_r   <= commit_r;
            state_r       <= S_OUT;
          end else begin
            slot_r <= slot_r + 3'd1;
          end
        end
        S_C_RD: state_r <= S_C_WR;
        S_C_WR: begin
          act_valid_r[i_r] <= 1'b1;
          i_r <= i_r + 6'd1;
          state_r <= (i_r + 6'd1 == fill_r) ? S_OUT : S_C_RD;
        end
        S_B_POP: state_r <= S_B_POPW;
        S_B_POPW: begin
          n_r     <= q_rd_r;
          head_r  <= head_r + 7'd1;
          state_r <= S_B_DEG;
        end
        S_B_DEG: begin
          d_r     <= deg_eff;
          slot_r  <= '0;
          state_r <= (deg_eff == '0) ? S_B_NEXT : S_B_SCAN;
        end
        S_B_SCAN: begin
          if (nt_ok) seen_r[nt_rd_r] <= 1'b1;
          if (slot_last) state_r <= S_B_NEXT;
          else slot_r <= slot_r + 3'd1;
        end
        S_B_NEXT: begin
          if (seen_r[t_r]) begin
            n_r     <= t_r;
            len_r   <= '0;
            state_r <= S_T_CHK;
          end else if (head_r < tail_r) begin
            state_r <= S_B_POP;
          end else begin
            pend_status_r <= ST_DISC;
            state_r       <= S_OUT;
          end
        end
        S_T_CHK: begin
          if (trace_end) begin
            state_r <= S_A_RD;
          end else begin
            len_r   <= len_r + 7'd1;
            state_r <= S_T_WAIT;
          end
        end
        S_T_WAIT: begin
          n_r     <= pred_rd_r;
          state_r <= S_T_CHK;
        end
        S_A_RD: begin
          if (len_r == '0) begin
            state_r <= S_OUT;
          end else begin
            len_r   <= len_r - 7'd1;
            state_r <= S_A_WR;
          end
        end
        S_A_WR: begin
          if (!cap_ok) begin
            pend_status_r <= ST_ARG;
            state_r       <= S_OUT;
          end else if ({1'b0, rev_rd_r} >= 7'(NODES)) begin
            pend_status_r <= ST_NODE;
            state_r       <= S_OUT;
          end else if (full) begin
            pend_status_r <= ST_FULL;
            state_r       <= S_OUT;
          end else begin
            state_r <= S_A_RD;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

`include "route_builder_bfs_path_unit_assert.svh"

  `RBP_ASSERT_NEXT(a_accept_busy, accept, state_r != S_IDLE)
  `RBP_ASSERT_NEXT(a_out_load, state_r == S_OUT && !(out_valid_r && out_stall),
                   out_valid_r && state_r == S_IDLE)
  `RBP_ASSERT_NOW(a_queue_bounds, state_r == S_B_NEXT || state_r == S_B_SCAN,
                  tail_r <= LEN_W'(NODES) && head_r <= tail_r)
  `RBP_ASSERT_NOW(a_single_write, state_r == S_C_WR, !bs_we && !q_we)

endmodule
`default_nettype wire

// File: test/route_builder_bfs_path_unit_tb.sv
// testbench for route_builder_bfs_path_unit: directed and random requests checked
// against a predictor of the table, bfs path search, validate and commit logic
// depends on rbp_pkg and the route_builder_bfs_path_unit rtl
`timescale 1ns / 1ps
module route_builder_bfs_path_unit_tb;
  import rbp_pkg::*;

  localparam int CYCLE_LIMIT = 3000000;
  localparam int TOTAL_REQS  = 580;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_t         in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_t        out_data;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  route_builder_bfs_path_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // predictor state
  logic [6:0] capacity;
  logic [7:0] build_nodes[ROUTE_SLOTS];
  int         fill;
  logic [7:0] active_nodes[ROUTE_SLOTS];
  logic [3:0] row_deg[NODES];
  logic [5:0] row_nbr[NODES*MAX_DEGREE];
  bit         nbr_written[NODES*MAX_DEGREE];

  out_t expected_results[$];
  out_t last_out;
  int   errors = 0;
  int   cycles = 0;
  int   reqs_sent = 0;
  int   stall_left = 0;
  bit   send_quiet = 0;
  bit   stall_quiet = 0;

  function automatic int cap_now();
    return (capacity < ROUTE_SLOTS) ? int'(capacity) : ROUTE_SLOTS;
  endfunction

  function automatic int written_prefix(int row);
    int p;
    p = 0;
    while (p < MAX_DEGREE && nbr_written[row*MAX_DEGREE+p]) p = p + 1;
    return p;
  endfunction

  function automatic logic [2:0] add_node(int n);
    if (cap_now() < MIN_CAPACITY) return ST_ARG;
    if (n >= NODES) return ST_NODE;
    if (fill >= cap_now() - 1) return ST_FULL;
    build_nodes[fill] = n[7:0];
    fill = fill + 1;
    return ST_OK;
  endfunction

  function automatic logic [2:0] add_shortest_path(int s, int t);
    int q[NODES];
    int prev[NODES];
    int rev[NODES];
    bit seen[NODES];
    int head, tail, n, d, nx, len, i;
    logic [2:0] st;
    if (s >= NODES || t >= NODES) return ST_ARG;
    if (s == t) return ST_OK;
    for (i = 0; i < NODES; i++) seen[i] = 0;
    head = 0;
    tail = 1;
    seen[s] = 1;
    prev[s] = s;
    q[0] = s;
    while (head < tail && !seen[t]) begin
      n = q[head];
      head = head + 1;
      d = row_deg[n];
      for (i = 0; i < d; i++) begin
        nx = row_nbr[n*MAX_DEGREE+i];
        if (!seen[nx] && tail < NODES) begin
          seen[nx] = 1;
          prev[nx] = n;
          q[tail] = nx;
          tail = tail + 1;
        end
      end
    end
    if (!seen[t]) return ST_DISC;
    n = t;
    len = 0;
    while (n != s && len < NODES) begin
      rev[len] = n;
      len = len + 1;
      n = prev[n];
    end
    while (len > 0) begin
      len = len - 1;
      st = add_node(rev[len]);
      if (st != ST_OK) return st;
    end
    return ST_OK;
  endfunction

  function automatic bit joined(int a, int b);
    int i;
    for (i = 0; i < row_deg[a]; i++)
      if (row_nbr[a*MAX_DEGREE+i] == b) return 1;
    return 0;
  endfunction

  function automatic logic [2:0] check_route(int s);
    int cur, i;
    if (cap_now() < MIN_CAPACITY || fill == 0 || fill >= cap_now() || s >= NODES)
      return ST_ARG;
    cur = s;
    for (i = 0; i < fill; i++) begin
      if (build_nodes[i] >= NODES) return ST_NODE;
      if (!joined(cur, build_nodes[i])) return ST_DISC;
      cur = build_nodes[i];
    end
    return ST_OK;
  endfunction

  function automatic out_t route_step_result(in_t r);
    out_t o;
    int i;
    o = '0;
    case (r.kind)
      K_CLEAR: fill = 0;
      K_NODE: o.status = add_node(r.node);
      K_PATH: o.status = add_shortest_path(r.node, r.target);
      K_CHECK: o.status = check_route(r.node);
      K_COMMIT: begin
        o.status = check_route(r.node);
        if (o.status != ST_OK) begin
          o.force_stop = 1'b1;
        end else begin
          for (i = 0; i < ROUTE_SLOTS; i++)
            active_nodes[i] = (i < fill) ? build_nodes[i] : END_MARK;
        end
      end
      K_WNB: begin
        if (r.node >= NODES) begin
          o.status = ST_NODE;
        end else begin
          row_nbr[r.node*MAX_DEGREE+r.slot] = r.neighbor;
          nbr_written[r.node*MAX_DEGREE+r.slot] = 1;
        end
      end
      K_WDEG: begin
        if (r.node >= NODES) o.status = ST_NODE;
        else if (r.degree > MAX_DEGREE) o.status = ST_ARG;
        else row_deg[r.node] = r.degree;
      end
      default: o.entry = active_nodes[r.index];
    endcase
    o.route_length = fill[5:0];
    return o;
  endfunction

  function automatic in_t mk(logic [2:0] k, int nd = 0, int tg = 0, int sl = 0,
                             int nb = 0, int dg = 0, int ix = 0);
    in_t r;
    r.kind = k;
    r.node = nd[7:0];
    r.target = tg[7:0];
    r.slot = sl[2:0];
    r.neighbor = nb[5:0];
    r.degree = dg[3:0];
    r.index = ix[5:0];
    return r;
  endfunction

  task automatic send_req(input in_t r);
    int gap;
    gap = send_quiet ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= r;
    do @(posedge clk); while (in_stall !== 1'b0);
    last_out = route_step_result(r);
    expected_results.push_back(last_out);
    reqs_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_capacity(input int v);
    drain();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= 3'(REG_CAP_LIMIT) << 2;
    pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    capacity = v[6:0];
  endtask

  // result check and output stall
  always @(posedge clk) begin
    out_t exp_r;
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        errors <= errors + 1;
        if (errors < 10) $display("unexpected result %h", out_data);
      end else begin
        exp_r = expected_results.pop_front();
        if (out_data.status !== exp_r.status ||
            out_data.route_length !== exp_r.route_length ||
            out_data.force_stop !== exp_r.force_stop ||
            out_data.entry !== exp_r.entry) begin
          errors <= errors + 1;
          if (errors < 10)
            $display("mismatch: exp st %0d len %0d stop %0d entry %0d, got %0d %0d %0d %0d",
                     exp_r.status, exp_r.route_length, exp_r.force_stop, exp_r.entry,
                     out_data.status, out_data.route_length, out_data.force_stop,
                     out_data.entry);
        end
      end
      stall_left = stall_quiet ? 0 : $urandom_range(0, 18);
    end else if (out_valid && stall_left > 0) begin
      stall_left = stall_left - 1;
    end
    out_stall <= (stall_left > 0);
  end

  task automatic test_table_and_paths();
    send_req(mk(K_WNB, 0, 0, 0, 1));
    send_req(mk(K_WNB, 0, 0, 1, 2));
    send_req(mk(K_WDEG, 0, 0, 0, 0, 2));
    send_req(mk(K_WNB, 1, 0, 0, 3));
    send_req(mk(K_WDEG, 1, 0, 0, 0, 1));
    send_req(mk(K_WNB, 63, 0, 7, 63));
    send_req(mk(K_WNB, 255, 0, 0, 0));
    send_req(mk(K_WDEG, 64, 0, 0, 0, 1));
    send_req(mk(K_WDEG, 0, 0, 0, 0, 9));
    send_req(mk(K_WDEG, 3, 0, 0, 0, 15));
    send_req(mk(K_PATH, 0, 3));
    send_req(mk(K_PATH, 3, 3));
    send_req(mk(K_PATH, 0, 255));
    send_req(mk(K_PATH, 200, 1));
    send_req(mk(K_PATH, 5, 0));
    send_req(mk(K_CHECK, 0));
    send_req(mk(K_CHECK, 1));
    send_req(mk(K_CHECK, 255));
    send_req(mk(K_COMMIT, 0));
    send_req(mk(K_READ, 0, 0, 0, 0, 0, 0));
    send_req(mk(K_READ, 0, 0, 0, 0, 0, 1));
    send_req(mk(K_READ, 0, 0, 0, 0, 0, 2));
    send_req(mk(K_READ, 0, 0, 0, 0, 0, 63));
    send_req(mk(K_COMMIT, 2));
    send_req(mk(K_NODE, 255));
    send_req(mk(K_NODE, 63));
    send_req(mk(K_CLEAR));
    send_req(mk(K_CHECK, 0));
  endtask

  task automatic test_capacity_limits();
    set_capacity(0);
    send_req(mk(K_NODE, 1));
    send_req(mk(K_PATH, 0, 3));
    send_req(mk(K_CHECK, 0));
    set_capacity(1);
    send_req(mk(K_NODE, 1));
    set_capacity(2);
    send_req(mk(K_NODE, 1));
    send_req(mk(K_NODE, 3));
    send_req(mk(K_CHECK, 0));
    send_req(mk(K_CLEAR));
    send_req(mk(K_PATH, 0, 3));
    set_capacity(64);
    send_req(mk(K_NODE, 3));
    send_req(mk(K_NODE, 1));
    set_capacity(3);
    send_req(mk(K_CHECK, 0));
    send_req(mk(K_COMMIT, 0));
    set_capacity(127);
    send_req(mk(K_CLEAR));
    send_req(mk(K_PATH, 0, 3));
    send_req(mk(K_COMMIT, 0));
  endtask

  task automatic edit_table();
    int n, row, sl;
    in_t r;
    n = $urandom_range(1, 4);
    repeat (n) begin
      row = $urandom_range(0, 15);
      sl = $urandom_range(0, 7);
      r = mk(K_WNB, row, $urandom, sl, $urandom_range(0, 15), $urandom, $urandom);
      if ($urandom_range(0, 9) == 0) r.node = 8'($urandom);
      if ($urandom_range(0, 9) == 0) r.neighbor = 6'($urandom);
      send_req(r);
      if ($urandom_range(0, 1) == 0) begin
        r = mk(K_WDEG, row, $urandom, $urandom, $urandom,
               $urandom_range(0, written_prefix(row)), $urandom);
        if ($urandom_range(0, 9) == 0) r.degree = 4'($urandom_range(9, 15));
        if ($urandom_range(0, 19) == 0) r.node = 8'($urandom);
        if (r.node < NODES && r.degree <= MAX_DEGREE &&
            r.degree > written_prefix(r.node))
          r.degree = 4'(written_prefix(r.node));
        send_req(r);
      end
    end
  endtask

  task automatic build_route();
    int s, cur, n, t, d;
    in_t r;
    s = $urandom_range(0, 15);
    cur = s;
    send_req(mk(K_CLEAR, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom));
    n = $urandom_range(1, 4);
    repeat (n) begin
      if ($urandom_range(0, 2) != 0) begin
        t = $urandom_range(0, 15);
        r = mk(K_PATH, cur, t, $urandom, $urandom, $urandom, $urandom);
        if ($urandom_range(0, 19) == 0) r.target = 8'($urandom);
        send_req(r);
        if (last_out.status == ST_OK) cur = t;
      end else begin
        d = row_deg[cur];
        t = (d > 0) ? row_nbr[cur*MAX_DEGREE + $urandom_range(0, d-1)]
                    : $urandom_range(0, 63);
        r = mk(K_NODE, t, $urandom, $urandom, $urandom, $urandom, $urandom);
        if ($urandom_range(0, 19) == 0) r.node = 8'($urandom);
        send_req(r);
        if (last_out.status == ST_OK) cur = t;
      end
    end
    if ($urandom_range(0, 1) == 0) send_req(mk(K_CHECK, s, $urandom, $urandom, $urandom));
    send_req(mk(K_COMMIT, ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255) : s));
    repeat ($urandom_range(1, 3)) send_req(mk(K_READ, $urandom, $urandom, $urandom,
                                              $urandom, $urandom, $urandom_range(0, 63)));
  endtask

  task automatic send_noise();
    in_t r;
    r = in_t'({$urandom, $urandom});
    if (r.kind == K_WDEG && r.node < NODES && r.degree <= MAX_DEGREE)
      r.degree = 4'($urandom_range(0, written_prefix(r.node)));
    send_req(r);
  endtask

  task automatic test_random_traffic();
    int next_cfg, sel;
    next_cfg = reqs_sent + 120;
    while (reqs_sent < TOTAL_REQS) begin
      if ($urandom_range(0, 9) == 0) send_quiet = !send_quiet;
      if ($urandom_range(0, 9) == 0) stall_quiet = !stall_quiet;
      if (reqs_sent >= next_cfg) begin
        sel = $urandom_range(0, 4);
        set_capacity(sel == 0 ? 127 : sel == 1 ? 2 : sel == 2 ? $urandom_range(0, 127) :
                     sel == 3 ? 64 : $urandom_range(20, 63));
        next_cfg = reqs_sent + 120;
      end
      sel = $urandom_range(0, 9);
      if (sel < 3) edit_table();
      else if (sel < 8) build_route();
      else send_noise();
    end
  endtask

  task automatic test_quiet_pause();
    drain();
    send_req(mk(K_READ, 0, 0, 0, 0, 0, 5));
  endtask

  initial begin
    capacity = CAP_RESET;
    fill = 0;
    for (int i = 0; i < ROUTE_SLOTS; i++) active_nodes[i] = END_MARK;
    for (int i = 0; i < NODES; i++) row_deg[i] = '0;
    for (int i = 0; i < NODES*MAX_DEGREE; i++) begin
      row_nbr[i] = '0;
      nbr_written[i] = 0;
    end
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_table_and_paths();
    test_capacity_limits();
    set_capacity(64);
    test_quiet_pause();
    test_random_traffic();
    drain();
    repeat (50) @(posedge clk);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
